// ===== rtl/core/prr_pkg.sv =====
// Shared types, widths and constants of the polyphase rational resampler.
`timescale 1ns / 1ps

package prr_pkg;

    // Default sizing of the top level.
    localparam int PRR_RING_DEPTH = 512;
    localparam int PRR_MAX_UP     = 16;

    // Coefficient store: entries 0..512.
    localparam int PRR_COEF_DEPTH = 513;
    localparam int PRR_COEF_LAST  = PRR_COEF_DEPTH - 1;
    localparam int PRR_COEF_AW    = $clog2(PRR_COEF_DEPTH);

    // Field widths.
    localparam int PRR_SAMPLE_W = 16;
    localparam int PRR_COEF_W   = 18;
    localparam int PRR_CIDX_W   = 10;
    localparam int PRR_RATE_W   = 5;
    localparam int PRR_TAP_W    = 10;
    localparam int PRR_DROP_W   = 9;

    // Configuration port.
    localparam int PRR_CFG_IDX_W  = 2;
    localparam int PRR_CFG_DATA_W = 10;

    // Datapath widths: Q1.15 x Q3.15 products, summed over up to 513 taps.
    localparam int PRR_PROD_W  = PRR_SAMPLE_W + PRR_COEF_W;
    localparam int PRR_ACC_W   = PRR_PROD_W + 10;
    localparam int PRR_FRAC_W  = 15;

    typedef enum logic [PRR_CFG_IDX_W-1:0] {
        CFG_UP_RATE    = 2'd0,
        CFG_DOWN_RATE  = 2'd1,
        CFG_TAP_LAST   = 2'd2,
        CFG_DROP_COUNT = 2'd3
    } t_cfg_reg;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_COEF   = 1'b1
    } t_opcode;

endpackage

// ===== rtl/core/prr_in_if.sv =====
// Input channel of the resampler: sample and coefficient-load items.
`timescale 1ns / 1ps

interface prr_in_if;
    import prr_pkg::*;

    logic                           valid;
    logic                           ready;
    logic                           opcode;
    logic signed [PRR_SAMPLE_W-1:0] sample_in;
    logic        [PRR_CIDX_W-1:0]   coef_index;
    logic signed [PRR_COEF_W-1:0]   coef_value;

    modport source (
        output valid, opcode, sample_in, coef_index, coef_value,
        input  ready
    );

    modport sink (
        input  valid, opcode, sample_in, coef_index, coef_value,
        output ready
    );
endinterface

// ===== rtl/core/prr_out_if.sv =====
// Output channel of the resampler: resampled values with an end-of-run flag.
`timescale 1ns / 1ps

interface prr_out_if;
    import prr_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [PRR_SAMPLE_W-1:0] sample_out;
    logic                           last_of_run;

    modport source (
        output valid, sample_out, last_of_run,
        input  ready
    );

    modport sink (
        input  valid, sample_out, last_of_run,
        output ready
    );
endinterface

// ===== rtl/core/polyphase_rational_resampler.sv =====
// Polyphase rational resampler: a shared multiply-accumulate under a small sequencer.
`timescale 1ns / 1ps

// The block converts a Q1.15 sample stream by the ratio up_rate : down_rate.
// An input transfer either loads one coefficient (opcode 1, no result) or
// pushes one sample into the ring buffer (opcode 0). For a sample, the
// sequencer walks the up_rate phases in turn; a phase chosen by the down_rate
// counter runs one multiply-accumulate per tap of that phase through a single
// 16 x 18 multiplier, then rounds (ties toward plus infinity) and saturates
// the sum to 16 bits. The block is not ready while it works on a sample.
// Waiting on a stalled output adds to the time a sample item takes. Results
// pass through an output register, so a new item is taken while the last
// result still waits for its transfer. Within one sample the newest result
// is held back one slot so that last_of_run can mark the final delivered
// output. The first drop_count outputs after a drop_count write are skipped
// without a multiply-accumulate and are not delivered. After reset the ring
// buffer is cleared to zero, one entry a cycle, and no item is accepted
// during that pass; configuration writes are taken during it as well, and
// otherwise the user must make them only while no sample is in flight, which
// the block itself does not enforce. Coefficients read by a filter must have
// been loaded first.
module polyphase_rational_resampler #(
    parameter int RING_DEPTH = prr_pkg::PRR_RING_DEPTH,
    parameter int MAX_UP     = prr_pkg::PRR_MAX_UP
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [prr_pkg::PRR_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [prr_pkg::PRR_CFG_DATA_W-1:0] i_cfg_data,
    prr_in_if.sink                            i_smp,
    prr_out_if.source                         o_res
);
    import prr_pkg::*;

    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam int STEP_W  = $clog2(MAX_UP + 1);
    localparam int Q_W     = PRR_ACC_W - PRR_FRAC_W;

    localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);
    localparam logic [PRR_TAP_W-1:0] TAP_MAX = PRR_TAP_W'(PRR_COEF_LAST);
    localparam logic [PRR_CIDX_W-1:0] CIDX_MAX = PRR_CIDX_W'(PRR_COEF_LAST);
    localparam logic signed [PRR_ACC_W-1:0] ROUND_BIAS =
        PRR_ACC_W'(1 << (PRR_FRAC_W - 1));
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((1 << (PRR_SAMPLE_W - 1)) - 1);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(1 << (PRR_SAMPLE_W - 1));
    localparam logic [PRR_SAMPLE_W-1:0] SAT_MAX = {1'b0, {(PRR_SAMPLE_W-1){1'b1}}};
    localparam logic [PRR_SAMPLE_W-1:0] SAT_MIN = {1'b1, {(PRR_SAMPLE_W-1){1'b0}}};

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PHASE,
        S_MAC,
        S_ROUND,
        S_EMIT,
        S_FLUSH
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [PRR_RATE_W-1:0] r_up_rate;
    logic [PRR_RATE_W-1:0] r_down_rate;
    logic [PRR_TAP_W-1:0]  r_tap_last;
    logic [PRR_DROP_W-1:0] r_drops_left;

    // Sequencer state.
    logic [RING_AW-1:0]    r_clr_addr;
    logic [RING_AW-1:0]    r_head;
    logic [RING_AW-1:0]    r_pos;
    logic [PRR_RATE_W-1:0] r_countdown;
    logic [STEP_W-1:0]     r_phase;
    logic [STEP_W-1:0]     r_step;
    logic [PRR_TAP_W-1:0]  r_k;

    // Multiply-accumulate pipeline.
    logic                         r_rd_v;
    logic                         r_mul_v;
    logic signed [PRR_PROD_W-1:0] r_prod;
    logic signed [PRR_ACC_W-1:0]  r_acc;
    logic [PRR_SAMPLE_W-1:0]      r_res;

    // Held-back result and output register.
    logic                    r_pend_v;
    logic [PRR_SAMPLE_W-1:0] r_pend;
    logic                    r_out_v;
    logic [PRR_SAMPLE_W-1:0] r_out_data;
    logic                    r_out_last;

    logic                    w_accept;
    logic                    w_is_coef;
    logic                    w_out_free;
    logic                    w_out_load;
    logic [STEP_W-1:0]       w_eff_up;
    logic [PRR_RATE_W-1:0]   w_reload;
    logic [PRR_RATE_W-1:0]   w_cd_dec;
    logic [PRR_TAP_W-1:0]    w_last;
    logic                    w_issue;
    logic                    w_phase_done;
    logic [RING_AW-1:0]      w_head_dec;
    logic [RING_AW-1:0]      w_pos_inc;
    logic signed [PRR_ACC_W-1:0] w_rounded;
    logic signed [Q_W-1:0]   w_q;
    logic [PRR_SAMPLE_W-1:0] w_sat;

    logic                    w_ring_we;
    logic [RING_AW-1:0]      w_ring_waddr;
    logic [PRR_SAMPLE_W-1:0] w_ring_wdata;
    logic [PRR_SAMPLE_W-1:0] w_ring_rdata;
    logic                    w_coef_we;
    logic [PRR_COEF_W-1:0]   w_coef_rdata;

    assign w_accept   = i_smp.valid && i_smp.ready;
    assign w_is_coef  = (t_opcode'(i_smp.opcode) == OP_COEF);
    assign w_out_free = !r_out_v || o_res.ready;

    // The held-back result moves into the output register in this cycle.
    assign w_out_load = r_pend_v && w_out_free &&
                        ((r_state == S_EMIT) || (r_state == S_FLUSH));

    // Effective rates: zero acts as one, and the phase count is capped.
    always_comb begin
        if (r_up_rate == '0) begin
            w_eff_up = STEP_W'(1);
        end else if (int'(r_up_rate) > MAX_UP) begin
            w_eff_up = STEP_W'(MAX_UP);
        end else begin
            w_eff_up = STEP_W'(r_up_rate);
        end
    end

    assign w_reload = (r_down_rate == '0) ? PRR_RATE_W'(1) : r_down_rate;
    assign w_cd_dec = r_countdown - PRR_RATE_W'(1);
    assign w_last   = (r_tap_last > TAP_MAX) ? TAP_MAX : r_tap_last;

    assign w_issue      = (r_state == S_MAC) && (r_k <= w_last);
    assign w_phase_done = (r_phase + STEP_W'(1)) == r_step;

    // The ring index wraps at RING_DEPTH, which need not be a power of two.
    assign w_head_dec = (r_head == '0) ? RING_LAST : r_head - RING_AW'(1);
    assign w_pos_inc  = (r_pos == RING_LAST) ? '0 : r_pos + RING_AW'(1);

    // Round to nearest with ties upward, then saturate to 16 bits.
    assign w_rounded = r_acc + ROUND_BIAS;
    assign w_q       = Q_W'(w_rounded >>> PRR_FRAC_W);

    always_comb begin
        if (w_q > Q_MAX) begin
            w_sat = SAT_MAX;
        end else if (w_q < Q_MIN) begin
            w_sat = SAT_MIN;
        end else begin
            w_sat = w_q[PRR_SAMPLE_W-1:0];
        end
    end

    // Ring writes come from the clearing pass or from an accepted sample.
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_ring_we    = 1'b1;
            w_ring_waddr = r_clr_addr;
            w_ring_wdata = '0;
        end else begin
            w_ring_we    = w_accept && !w_is_coef;
            w_ring_waddr = w_head_dec;
            w_ring_wdata = i_smp.sample_in;
        end
    end

    assign w_coef_we = w_accept && w_is_coef && (i_smp.coef_index <= CIDX_MAX);

    prr_ram #(
        .WIDTH (PRR_SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ring_we),
        .i_waddr (w_ring_waddr),
        .i_wdata (w_ring_wdata),
        .i_raddr (r_pos),
        .o_rdata (w_ring_rdata)
    );

    prr_ram #(
        .WIDTH (PRR_COEF_W),
        .DEPTH (PRR_COEF_DEPTH)
    ) u_coef (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (i_smp.coef_index[PRR_COEF_AW-1:0]),
        .i_wdata (i_smp.coef_value),
        .i_raddr (r_k[PRR_COEF_AW-1:0]),
        .o_rdata (w_coef_rdata)
    );

    always_ff @(posedge i_clk) begin
        // Payload of the multiply-accumulate pipeline.
        r_prod <= signed'(w_ring_rdata) * signed'(w_coef_rdata);

        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_up_rate    <= PRR_RATE_W'(8);
            r_down_rate  <= PRR_RATE_W'(5);
            r_tap_last   <= '0;
            r_drops_left <= '0;
            r_clr_addr   <= '0;
            r_head       <= '0;
            r_pos        <= '0;
            r_countdown  <= PRR_RATE_W'(1);
            r_phase      <= '0;
            r_step       <= STEP_W'(1);
            r_k          <= '0;
            r_rd_v       <= 1'b0;
            r_mul_v      <= 1'b0;
            r_acc        <= '0;
            r_res        <= '0;
            r_pend_v     <= 1'b0;
            r_pend       <= '0;
            r_out_v      <= 1'b0;
            r_out_data   <= '0;
            r_out_last   <= 1'b0;
        end else begin
            r_rd_v  <= w_issue;
            r_mul_v <= r_rd_v;

            if (r_out_v && o_res.ready && !w_out_load) begin
                r_out_v <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + RING_AW'(1);
                    if (r_clr_addr == RING_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept && !w_is_coef) begin
                        r_head  <= w_head_dec;
                        r_phase <= '0;
                        r_step  <= w_eff_up;
                        r_state <= S_PHASE;
                    end
                end
                S_PHASE: begin
                    if (w_cd_dec == '0) begin
                        r_countdown <= w_reload;
                        if (r_drops_left != '0) begin
                            // A dropped output still uses up its phase.
                            r_drops_left <= r_drops_left - PRR_DROP_W'(1);
                            if (w_phase_done) begin
                                r_state <= S_FLUSH;
                            end else begin
                                r_phase <= r_phase + STEP_W'(1);
                            end
                        end else begin
                            r_k     <= PRR_TAP_W'(r_phase);
                            r_pos   <= r_head;
                            r_acc   <= '0;
                            r_state <= S_MAC;
                        end
                    end else begin
                        r_countdown <= w_cd_dec;
                        if (w_phase_done) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_phase <= r_phase + STEP_W'(1);
                        end
                    end
                end
                S_MAC: begin
                    if (w_issue) begin
                        r_k   <= r_k + PRR_TAP_W'(r_step);
                        r_pos <= w_pos_inc;
                    end
                    if (r_mul_v) begin
                        r_acc <= r_acc + PRR_ACC_W'(r_prod);
                    end
                    if (!w_issue && !r_rd_v && !r_mul_v) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_res   <= w_sat;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // The held-back result is known not to be the last one.
                    if (!r_pend_v || w_out_free) begin
                        if (r_pend_v) begin
                            r_out_v    <= 1'b1;
                            r_out_data <= r_pend;
                            r_out_last <= 1'b0;
                        end
                        r_pend   <= r_res;
                        r_pend_v <= 1'b1;
                        if (w_phase_done) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_phase <= r_phase + STEP_W'(1);
                            r_state <= S_PHASE;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_out_v    <= 1'b1;
                        r_out_data <= r_pend;
                        r_out_last <= 1'b1;
                        r_pend_v   <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Configuration writes; a drop_count write reloads the drop counter.
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    CFG_UP_RATE:    r_up_rate    <= i_cfg_data[PRR_RATE_W-1:0];
                    CFG_DOWN_RATE:  r_down_rate  <= i_cfg_data[PRR_RATE_W-1:0];
                    CFG_TAP_LAST:   r_tap_last   <= i_cfg_data[PRR_TAP_W-1:0];
                    CFG_DROP_COUNT: r_drops_left <= i_cfg_data[PRR_DROP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign i_smp.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_v;
    assign o_res.sample_out  = r_out_data;
    assign o_res.last_of_run = r_out_last;
endmodule

// ===== rtl/core/prr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module prr_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 512,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/prr_checker.sv =====
// Port-level checks of the polyphase rational resampler, bound to its top level.
`timescale 1ns / 1ps

module prr_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_in_opcode,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [prr_pkg::PRR_SAMPLE_W-1:0] i_out_sample,
    input logic                             i_out_last
);
    import prr_pkg::*;

    // A sample transfer starts the phase walk, so the input closes at once.
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (t_opcode'(i_in_opcode) == OP_SAMPLE)
        |=> !i_in_ready)
        else $error("input stayed ready after a sample transfer");

    // A coefficient load finishes in its own cycle.
    a_coef_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (t_opcode'(i_in_opcode) == OP_COEF)
        |=> i_in_ready)
        else $error("input not ready after a coefficient transfer");

    // New results are only produced while the sequencer is busy.
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared while the input was ready");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready
        |=> i_out_valid && $stable(i_out_sample) && $stable(i_out_last))
        else $error("stalled result changed");
endmodule

bind polyphase_rational_resampler prr_checker u_prr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_smp.valid),
    .i_in_ready   (i_smp.ready),
    .i_in_opcode  (i_smp.opcode),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_sample (o_res.sample_out),
    .i_out_last   (o_res.last_of_run)
);
